@@ rtl/lrcs_pkg.sv @@
// Shared types and constants for the least-run-count scheduler.
`default_nettype none
package lrcs_pkg;

  localparam int unsigned TASK_SLOTS_DEF = 256;
  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned KIND_W         = 2;
  localparam int unsigned TICKS_W        = 32;
  localparam int unsigned SLOT_W         = 8;

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_YIELD  = 2'd2,
    KIND_SLEEP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_BLOCKED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CUR_RD,
    S_CUR_WR,
    S_SCAN,
    S_FIX_RD,
    S_FIX_WR,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

@@ rtl/least_run_count_scheduler_top.sv @@
// Top level of the least-run-count task scheduler.
// Input channel: in_valid / in_stall with in_kind (create, tick, yield, sleep)
// and in_sleep_ticks. One beat in gives exactly one beat out.
// Result channel: out_valid / out_stall with out_slot, out_table_full and
// out_none_runnable, held in an output register.
// Task state lives in one memory of TASK_SLOTS entries with a registered read.
// Create and schedule events both run a scan of the table that reads one
// table entry per cycle. The block takes one event at a time and is ready
// for the next once the result is loaded into the output register. After
// reset the block clears every table entry in one pass, writing the boot
// task into slot 0; in_stall stays high during that pass.
// A stalled result holds in the output register; a new event may be taken
// meanwhile, and its result waits inside until the register frees.
`default_nettype none
module least_run_count_scheduler_top #(
  parameter int unsigned TASK_SLOTS = lrcs_pkg::TASK_SLOTS_DEF,
  parameter int unsigned COUNT_BITS = lrcs_pkg::COUNT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [lrcs_pkg::KIND_W-1:0]  in_kind,
  input  wire logic [lrcs_pkg::TICKS_W-1:0] in_sleep_ticks,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [lrcs_pkg::SLOT_W-1:0]       out_slot,
  output logic                             out_table_full,
  output logic                             out_none_runnable
);
  import lrcs_pkg::*;

  localparam int unsigned IW = $clog2(TASK_SLOTS);
  localparam int unsigned EW = 3 + 2 * COUNT_BITS;

  logic              res_vld;
  logic              res_ready;
  logic [SLOT_W-1:0] res_slot;
  logic              res_table_full;
  logic              res_none_runnable;
  logic              mem_rd_en;
  logic [IW-1:0]     mem_rd_addr;
  logic [EW-1:0]     mem_rd_data;
  logic              mem_wr_en;
  logic [IW-1:0]     mem_wr_addr;
  logic [EW-1:0]     mem_wr_data;

  logic              out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_full_r;
  logic              out_none_r;

  lrcs_ctrl #(
    .TASK_SLOTS (TASK_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_sleep_ticks    (in_sleep_ticks),
    .res_vld           (res_vld),
    .res_ready         (res_ready),
    .res_slot          (res_slot),
    .res_table_full    (res_table_full),
    .res_none_runnable (res_none_runnable),
    .mem_rd_en         (mem_rd_en),
    .mem_rd_addr       (mem_rd_addr),
    .mem_rd_data       (mem_rd_data),
    .mem_wr_en         (mem_wr_en),
    .mem_wr_addr       (mem_wr_addr),
    .mem_wr_data       (mem_wr_data)
  );

  lrcs_mem #(
    .DEPTH (TASK_SLOTS),
    .WIDTH (EW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld && res_ready) begin
      out_slot_r <= res_slot;
      out_full_r <= res_table_full;
      out_none_r <= res_none_runnable;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_slot          = out_slot_r;
  assign out_table_full    = out_full_r;
  assign out_none_runnable = out_none_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted beat did not make the block busy");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && !res_ready |=> res_vld)
    else $error("pending result dropped before the output register freed");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> in_stall)
    else $error("input taken while a result was pending");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> !(res_table_full && res_none_runnable))
    else $error("table full and none runnable flagged together");

endmodule
`default_nettype wire

@@ rtl/lrcs_mem.sv @@
// Task table memory: one write port, one registered read port.
`default_nettype none
module lrcs_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 67
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/lrcs_ctrl.sv @@
// Sequencer: clear pass, current-task update, table scan and final pick.
`default_nettype none
module lrcs_ctrl #(
  parameter int unsigned TASK_SLOTS = 256,
  parameter int unsigned COUNT_BITS = 32,
  localparam int unsigned IW = $clog2(TASK_SLOTS),
  localparam int unsigned EW = 3 + 2 * COUNT_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [lrcs_pkg::KIND_W-1:0]  in_kind,
  input  wire logic [lrcs_pkg::TICKS_W-1:0] in_sleep_ticks,
  output logic                             res_vld,
  input  wire logic                        res_ready,
  output logic [lrcs_pkg::SLOT_W-1:0]       res_slot,
  output logic                             res_table_full,
  output logic                             res_none_runnable,
  output logic                             mem_rd_en,
  output logic [IW-1:0]                    mem_rd_addr,
  input  wire logic [EW-1:0]               mem_rd_data,
  output logic                             mem_wr_en,
  output logic [IW-1:0]                    mem_wr_addr,
  output logic [EW-1:0]                    mem_wr_data
);
  import lrcs_pkg::*;

  localparam int unsigned CB = COUNT_BITS;
  localparam logic [IW-1:0] LAST = IW'(TASK_SLOTS - 1);
  localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

  state_t          state_r, state_nxt;
  kind_t           kind_r, kind_nxt;
  logic [TICKS_W-1:0] ticks_r, ticks_nxt;
  logic [IW-1:0]   cur_r, cur_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic            issue_r, issue_nxt;
  logic            pvld_r, pvld_nxt;
  logic [IW-1:0]   pidx_r, pidx_nxt;
  logic            found_r, found_nxt;
  logic [IW-1:0]   best_r, best_nxt;
  logic [CB-1:0]   best_run_r, best_run_nxt;
  logic [IW-1:0]   res_slot_r, res_slot_nxt;
  logic            res_full_r, res_full_nxt;
  logic            res_none_r, res_none_nxt;

  logic            e_used;
  status_t         e_stat;
  logic [CB-1:0]   e_run;
  logic [CB-1:0]   e_wait;
  status_t         s1;
  logic [CB-1:0]   r1;
  logic [CB-1:0]   w1;
  logic [63:0]     ticks64;

  assign e_wait  = mem_rd_data[CB-1:0];
  assign e_run   = mem_rd_data[2*CB-1:CB];
  assign e_stat  = status_t'(mem_rd_data[2*CB+1:2*CB]);
  assign e_used  = mem_rd_data[2*CB+2];
  assign ticks64 = 64'(ticks_r);

  assign res_slot          = SLOT_W'(res_slot_r);
  assign res_table_full    = res_full_r;
  assign res_none_runnable = res_none_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cur_r   <= '0;
      idx_r   <= '0;
      issue_r <= 1'b0;
      pvld_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      idx_r   <= idx_nxt;
      issue_r <= issue_nxt;
      pvld_r  <= pvld_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    ticks_r    <= ticks_nxt;
    pidx_r     <= pidx_nxt;
    best_r     <= best_nxt;
    best_run_r <= best_run_nxt;
    res_slot_r <= res_slot_nxt;
    res_full_r <= res_full_nxt;
    res_none_r <= res_none_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    ticks_nxt    = ticks_r;
    cur_nxt      = cur_r;
    idx_nxt      = idx_r;
    issue_nxt    = issue_r;
    pvld_nxt     = 1'b0;
    pidx_nxt     = pidx_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    best_run_nxt = best_run_r;
    res_slot_nxt = res_slot_r;
    res_full_nxt = res_full_r;
    res_none_nxt = res_none_r;
    in_stall     = 1'b1;
    res_vld      = 1'b0;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = '0;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = '0;
    mem_wr_data  = '0;
    s1           = e_stat;
    r1           = e_run;
    w1           = e_wait;
    unique case (state_r)
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx_r;
        if (idx_r == '0) begin
          mem_wr_data = {1'b1, ST_RUNNABLE, CB'(1), {CB{1'b0}}};
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          kind_nxt  = kind_t'(in_kind);
          ticks_nxt = in_sleep_ticks;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          if (kind_t'(in_kind) == KIND_CREATE) begin
            issue_nxt = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_CUR_RD;
          end
        end
      end
      S_CUR_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = cur_r;
        state_nxt   = S_CUR_WR;
      end
      S_CUR_WR: begin
        if (kind_r == KIND_SLEEP && ticks_r != '0) begin
          s1 = ST_BLOCKED;
          w1 = (ticks64 > 64'(CNT_MAX)) ? CNT_MAX : CB'(ticks64);
        end
        if (e_used && s1 == ST_RUNNING) begin
          s1 = ST_RUNNABLE;
        end
        if (kind_r == KIND_TICK && e_run != CNT_MAX) begin
          r1 = e_run + 1'b1;
        end
        mem_wr_en   = 1'b1;
        mem_wr_addr = cur_r;
        mem_wr_data = {e_used, s1, r1, w1};
        issue_nxt   = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        if (issue_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_r;
          idx_nxt     = idx_r + 1'b1;
          pvld_nxt    = 1'b1;
          pidx_nxt    = idx_r;
          if (idx_r == LAST) begin
            issue_nxt = 1'b0;
          end
        end
        if (pvld_r) begin
          if (kind_r == KIND_CREATE) begin
            if (!e_used && !found_r) begin
              found_nxt = 1'b1;
              best_nxt  = pidx_r;
            end
          end else begin
            if (kind_r == KIND_TICK && e_used && e_stat == ST_BLOCKED) begin
              w1 = (e_wait != '0) ? e_wait - 1'b1 : e_wait;
              if (w1 == '0) begin
                s1 = ST_RUNNABLE;
              end
              mem_wr_en   = 1'b1;
              mem_wr_addr = pidx_r;
              mem_wr_data = {e_used, s1, e_run, w1};
            end
            if (e_used && s1 == ST_RUNNABLE && (!found_r || e_run < best_run_r)) begin
              found_nxt    = 1'b1;
              best_nxt     = pidx_r;
              best_run_nxt = e_run;
            end
          end
          if (pidx_r == LAST) begin
            if (kind_r == KIND_CREATE) begin
              res_none_nxt = 1'b0;
              res_full_nxt = !found_nxt;
              res_slot_nxt = found_nxt ? best_nxt : '0;
              if (found_nxt) begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = best_nxt;
                mem_wr_data = {1'b1, ST_RUNNABLE, {CB{1'b0}}, {CB{1'b0}}};
              end
              state_nxt = S_DONE;
            end else begin
              res_none_nxt = !found_nxt;
              if (!found_nxt) begin
                best_nxt = cur_r;
              end
              state_nxt = S_FIX_RD;
            end
          end
        end
      end
      S_FIX_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = best_r;
        state_nxt   = S_FIX_WR;
      end
      S_FIX_WR: begin
        mem_wr_en    = 1'b1;
        mem_wr_addr  = best_r;
        mem_wr_data  = {e_used, ST_RUNNING, e_run, e_wait};
        cur_nxt      = best_r;
        res_slot_nxt = best_r;
        res_full_nxt = 1'b0;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        res_vld = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ tb/sv/tb_least_run_count_scheduler_top.sv @@
// Self-checking testbench for the least-run-count task scheduler top level.
`timescale 1ns / 100ps
module tb_least_run_count_scheduler_top;
  import lrcs_pkg::*;

  localparam int unsigned SLOTS = TASK_SLOTS_DEF;
  localparam int unsigned CBITS = COUNT_BITS_DEF;
  localparam logic [CBITS-1:0] CNT_MAX = '1;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              full;
    logic              none;
  } sched_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [KIND_W-1:0]   in_kind;
  logic [TICKS_W-1:0]  in_sleep_ticks;
  logic                out_valid;
  logic                out_stall;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_table_full;
  logic                out_none_runnable;

  logic                 used_q [SLOTS];
  status_t              status_q [SLOTS];
  logic [CBITS-1:0]     runs_q [SLOTS];
  logic [CBITS-1:0]     waits_q [SLOTS];
  int unsigned          cur_slot;

  sched_result_t        pending_q [$];
  int unsigned          errors;
  int unsigned          beats_in;
  int unsigned          beats_out;
  int unsigned          full_seen;
  int unsigned          none_seen;
  int unsigned          idle_cycles;
  bit                   hold_out;
  bit                   quiet_out;

  least_run_count_scheduler_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_sleep_ticks    (in_sleep_ticks),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_slot          (out_slot),
    .out_table_full    (out_table_full),
    .out_none_runnable (out_none_runnable)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic table_reset();
    for (int i = 0; i < SLOTS; i++) begin
      used_q[i] = 1'b0;
      status_q[i] = ST_IDLE;
      runs_q[i] = '0;
      waits_q[i] = '0;
    end
    used_q[0] = 1'b1;
    status_q[0] = ST_RUNNABLE;
    runs_q[0] = 1;
    cur_slot = 0;
  endtask

  function automatic sched_result_t schedule_event(kind_t kind, logic [TICKS_W-1:0] ticks);
    sched_result_t r;
    int unsigned best;
    bit found;
    r = '0;
    found = 1'b0;
    best = 0;
    if (kind == KIND_CREATE) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!found && !used_q[i]) begin
          found = 1'b1;
          best = i;
        end
      end
      if (found) begin
        used_q[best] = 1'b1;
        status_q[best] = ST_RUNNABLE;
        runs_q[best] = '0;
        waits_q[best] = '0;
        r.slot = best[SLOT_W-1:0];
      end else begin
        r.full = 1'b1;
      end
      return r;
    end
    if (kind == KIND_SLEEP && ticks != 0) begin
      status_q[cur_slot] = ST_BLOCKED;
      waits_q[cur_slot] = ticks;
    end
    if (used_q[cur_slot] && status_q[cur_slot] == ST_RUNNING)
      status_q[cur_slot] = ST_RUNNABLE;
    if (kind == KIND_TICK) begin
      if (runs_q[cur_slot] != CNT_MAX)
        runs_q[cur_slot]++;
      for (int i = 0; i < SLOTS; i++) begin
        if (used_q[i] && status_q[i] == ST_BLOCKED) begin
          if (waits_q[i] != 0)
            waits_q[i]--;
          if (waits_q[i] == 0)
            status_q[i] = ST_RUNNABLE;
        end
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (used_q[i] && status_q[i] == ST_RUNNABLE && (!found || runs_q[i] < runs_q[best])) begin
        best = i;
        found = 1'b1;
      end
    end
    if (!found)
      best = cur_slot;
    r.none = !found;
    status_q[best] = ST_RUNNING;
    cur_slot = best;
    r.slot = best[SLOT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    errors++;
    $display("mismatch on result %0d: %s got %0d, expected %0d", beats_out, what, got, want);
  endtask

  task automatic send_event(kind_t kind, logic [TICKS_W-1:0] ticks);
    int unsigned gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0)
      gap = 0;
    if (gap != 0)
      in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_sleep_ticks <= ticks;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_q.push_back(schedule_event(kind, ticks));
    beats_in++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_out++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("unexpected result beat, slot %0d", out_slot);
      end else begin
        want = pending_q.pop_front();
        if (out_slot !== want.slot) report_mismatch("slot", out_slot, want.slot);
        if (out_table_full !== want.full)
          report_mismatch("table_full", out_table_full, want.full);
        if (out_none_runnable !== want.none)
          report_mismatch("none_runnable", out_none_runnable, want.none);
        full_seen += want.full;
        none_seen += want.none;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_out)
      out_stall <= 1'b1;
    else if (quiet_out)
      out_stall <= 1'b0;
    else if ($urandom_range(0, 29) == 0)
      out_stall <= 1'b1;
    else if ($urandom_range(0, 3) == 0)
      out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_q.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    send_event(KIND_TICK, 0);
    send_event(KIND_YIELD, 0);
    send_event(KIND_SLEEP, 0);
    send_event(KIND_SLEEP, 3);
    send_event(KIND_YIELD, 0);
    send_event(KIND_TICK, 0);
    send_event(KIND_CREATE, 0);
    send_event(KIND_CREATE, 32'hFFFF_FFFF);
    send_event(KIND_SLEEP, 32'hFFFF_FFFF);
    send_event(KIND_SLEEP, 32'h8000_0001);
    send_event(KIND_YIELD, 32'h5555_5555);
    send_event(KIND_TICK, 32'hAAAA_AAAA);
    send_event(KIND_SLEEP, 1);
    send_event(KIND_TICK, 0);
    send_event(KIND_TICK, 0);
    drain();
  endtask

  task automatic test_table_full();
    for (int i = 0; i < SLOTS + 3; i++)
      send_event(KIND_CREATE, $urandom);
    send_event(KIND_TICK, 0);
    drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_out = 1'b1;
        repeat (3 * (SLOTS + 10)) @(posedge clk);
        hold_out = 1'b0;
      end
      begin
        for (int i = 0; i < 4; i++)
          send_event(kind_t'($urandom_range(1, 2)), 0);
        in_valid <= 1'b0;
      end
    join
    drain();
  endtask

  task automatic test_random(int unsigned count);
    kind_t k;
    logic [TICKS_W-1:0] t;
    for (int i = 0; i < count; i++) begin
      quiet_out = (i % 200) < 40;
      k = kind_t'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
        0: t = 0;
        1: t = $urandom;
        default: t = $urandom_range(1, 6);
      endcase
      if (k == KIND_CREATE && $urandom_range(0, 2) != 0)
        k = KIND_TICK;
      send_event(k, t);
      if (i % 150 == 149)
        drain();
    end
    quiet_out = 1'b0;
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = '0;
    in_sleep_ticks = '0;
    out_stall = 1'b0;
    hold_out = 1'b0;
    quiet_out = 1'b0;
    errors = 0;
    beats_in = 0;
    beats_out = 0;
    full_seen = 0;
    none_seen = 0;
    idle_cycles = 0;
    table_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(300);
    test_table_full();
    test_random(160);
    repeat (2 * SLOTS + 20) @(posedge clk);
    $display("covered %0d events, %0d results; %0d table-full and %0d none-runnable cases",
             beats_in, beats_out, full_seen, none_seen);
    if (errors == 0 && pending_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
